@@ hdl/assert_macros.svh @@
// Assertion macros for the verification-only checker of the hash block.
// Every macro samples on the rising edge of clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define M3H_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("m3h assertion failed");

// Clocked assertion that stays active through reset.
`define M3H_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("m3h reset assertion failed");

`endif

@@ hdl/m3h_pkg.sv @@
// Package for the MurmurHash3 word stream hash: mixing constants and the
// scrambled-word item type that travels from the front end to the back end.
// No dependencies.
package m3h_pkg;

  localparam int unsigned WORD_W = 32;

  localparam logic [WORD_W-1:0] MUR_C1  = 32'hcc9e2d51;
  localparam logic [WORD_W-1:0] MUR_C2  = 32'h1b873593;
  localparam logic [WORD_W-1:0] MUR_ADD = 32'he6546b64;
  localparam logic [WORD_W-1:0] MUR_F1  = 32'h85ebca6b;
  localparam logic [WORD_W-1:0] MUR_F2  = 32'hc2b2ae35;

  // Bytes added to the message length for every valid word.
  localparam logic [WORD_W-1:0] BYTES_PER_WORD = 32'd4;

  // One classified item after key scrambling.
  typedef struct packed {
    logic [WORD_W-1:0] key;
    logic              word_valid;
    logic              last;
  } scr_item_t;

endpackage

@@ hdl/m3h_front.sv @@
// Front end: accepts input items, scrambles the key word in two multiply
// stages and drops items that carry neither a word nor an end marker.
// Depends on m3h_pkg.
module m3h_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [m3h_pkg::WORD_W-1:0]   in_word,
  input  logic                         in_word_valid,
  input  logic                         in_last,
  output logic                         push,
  input  logic                         push_ready,
  output m3h_pkg::scr_item_t           push_item
);
  import m3h_pkg::*;

  logic              s1_valid;
  logic [WORD_W-1:0] s1_prod;
  logic              s1_word_valid;
  logic              s1_last;
  logic              s2_valid;
  scr_item_t         s2_item;
  logic              advance;
  logic [WORD_W-1:0] prod1_next;
  logic [WORD_W-1:0] rot15;
  logic [WORD_W-1:0] prod2_next;

  // The whole pipe moves unless a needed push is held off by a full queue.
  assign push     = s2_valid && (s2_item.word_valid || s2_item.last);
  assign advance  = !push || push_ready;
  assign in_ready = advance;
  assign push_item = s2_item;

  // Scramble arithmetic: multiply, rotate left 15, multiply.
  always_comb begin
    prod1_next = in_word * MUR_C1;
    rot15      = {s1_prod[16:0], s1_prod[31:17]};
    prod2_next = rot15 * MUR_C2;
  end

  // Control state of both stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
    end
  end

  // Payload of both stages.
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_prod            <= prod1_next;
      s1_word_valid      <= in_word_valid;
      s1_last            <= in_last;
      s2_item.key        <= prod2_next;
      s2_item.word_valid <= s1_word_valid;
      s2_item.last       <= s1_last;
    end
  end

endmodule

@@ hdl/m3h_queue.sv @@
// Short queue between the front end and the back end, with a registered
// head entry so that the memory read happens in a clocked block.
// Depends on m3h_pkg.
module m3h_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  m3h_pkg::scr_item_t in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output m3h_pkg::scr_item_t out_item
);
  import m3h_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  scr_item_t        mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             wr_en;
  logic             load;

  assign in_ready = (count != CNT_W'(DEPTH));
  assign wr_en    = in_valid && in_ready;
  // Refill the head register whenever it is empty or being taken.
  assign load     = (count != '0) && (!out_valid || out_ready);

  // Storage write and registered head read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= in_item;
    end
    if (load) begin
      out_item <= mem[rd_ptr];
    end
  end

  // Pointers, fill count and head valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (load) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !load) begin
        count <= count + 1'b1;
      end else if (load && !wr_en) begin
        count <= count - 1'b1;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ hdl/m3h_back.sv @@
// Back end: mixes scrambled words into the running hash and byte count,
// then finalizes on the last item through a three-stage avalanche pipe.
// Depends on m3h_pkg.
module m3h_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_ready,
  input  m3h_pkg::scr_item_t           item,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [m3h_pkg::WORD_W-1:0]   out_hash
);
  import m3h_pkg::*;

  logic [WORD_W-1:0] running_hash;
  logic [WORD_W-1:0] byte_count;
  logic [WORD_W-1:0] hash_next;
  logic [WORD_W-1:0] byte_count_next;
  logic [WORD_W-1:0] mix_x;
  logic [WORD_W-1:0] mix_rot;
  logic              fin_adv;
  logic              pop;
  logic              fa_valid;
  logic              fb_valid;
  logic              fc_valid;
  logic [WORD_W-1:0] fa;
  logic [WORD_W-1:0] fb;
  logic [WORD_W-1:0] fc;
  logic [WORD_W-1:0] fb_next;
  logic [WORD_W-1:0] fc_next;

  // Finalization moves whenever the output register is free or taken.
  assign fin_adv    = !out_valid || out_ready;
  assign item_ready = !item.last || fin_adv;
  assign pop        = item_valid && item_ready;

  // Hash recurrence: xor, rotate left 13, times five, plus constant.
  always_comb begin
    mix_x   = running_hash ^ item.key;
    mix_rot = {mix_x[18:0], mix_x[31:19]};
    if (item.word_valid) begin
      hash_next       = (mix_rot << 2) + mix_rot + MUR_ADD;
      byte_count_next = byte_count + BYTES_PER_WORD;
    end else begin
      hash_next       = running_hash;
      byte_count_next = byte_count;
    end
  end

  // Avalanche multiplies, one per stage.
  always_comb begin
    fb_next = (fa ^ (fa >> 16)) * MUR_F1;
    fc_next = (fb ^ (fb >> 13)) * MUR_F2;
  end

  // Running state; a finished message returns it to zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= '0;
      byte_count   <= '0;
    end else if (pop) begin
      if (item.last) begin
        running_hash <= '0;
        byte_count   <= '0;
      end else begin
        running_hash <= hash_next;
        byte_count   <= byte_count_next;
      end
    end
  end

  // Finalization control.
  always_ff @(posedge clk) begin
    if (rst) begin
      fa_valid  <= 1'b0;
      fb_valid  <= 1'b0;
      fc_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (fin_adv) begin
      fa_valid  <= pop && item.last;
      fb_valid  <= fa_valid;
      fc_valid  <= fb_valid;
      out_valid <= fc_valid;
    end
  end

  // Finalization payload.
  always_ff @(posedge clk) begin
    if (fin_adv) begin
      fa       <= hash_next ^ byte_count_next;
      fb       <= fb_next;
      fc       <= fc_next;
      out_hash <= fc ^ (fc >> 16);
    end
  end

endmodule

@@ hdl/murmur3_word_stream_hash_top.sv @@
// Result path: a hash leaves once its last item has passed, in order, the second scramble
// stage, the queue write, the head read, the mix, two avalanche multiplies and
// the final xor-shift. Throughput: one item per cycle while both sides
// flow; the queue absorbs short stalls. Reset (rst, synchronous) empties all
// stages and the queue and clears the running hash and byte count to zero.
module murmur3_word_stream_hash_top #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] word
  input  logic        s_axis_tuser,   // [0] word_valid
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [31:0] hash
);
  import m3h_pkg::*;

  logic      push;
  logic      push_ready;
  scr_item_t push_item;
  logic      q_valid;
  logic      q_ready;
  scr_item_t q_item;

  // Scramble and classify.
  m3h_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .in_word       (s_axis_tdata),
    .in_word_valid (s_axis_tuser),
    .in_last       (s_axis_tlast),
    .push          (push),
    .push_ready    (push_ready),
    .push_item     (push_item)
  );

  // Decoupling queue.
  m3h_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (push),
    .in_ready  (push_ready),
    .in_item   (push_item),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_item  (q_item)
  );

  // Mix and finalize.
  m3h_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (q_valid),
    .item_ready (q_ready),
    .item       (q_item),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_hash   (m_axis_tdata)
  );

endmodule

@@ hdl/m3h_checker.sv @@
// Port-level checks for the hash block, attached to the top level by bind.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module m3h_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [31:0] s_axis_tdata,
  input logic        s_axis_tuser,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  // A stalled result keeps its value.
  `M3H_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))

  // Reset leaves no result pending.
  `M3H_ASSERT_RST(a_reset_no_result, rst |=> !m_axis_tvalid)

  // An empty pipe is ready for input right after reset.
  `M3H_ASSERT_RST(a_reset_ready, rst |=> s_axis_tready)

endmodule

bind murmur3_word_stream_hash_top m3h_checker u_m3h_checker (.*);

@@ tb/murmur3_word_stream_hash_checker.sv @@
// Scoreboard for the MurmurHash3 word stream hash: watches both stream channels,
// predicts every hash from the accepted words and compares it with the output.
// Depends on m3h_pkg for the mixing constants.
module murmur3_word_stream_hash_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] word
  input  logic        s_axis_tuser,   // [0] word_valid
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,   // [31:0] hash
  output int unsigned mismatches,
  output int unsigned hashes_waiting,
  output int unsigned words_seen,
  output int unsigned messages_seen,
  output int unsigned empty_messages
);
  timeunit 1ns;
  timeprecision 1ps;
  import m3h_pkg::*;

  // Predicted hash state of the message in progress.
  logic [WORD_W-1:0] hash_state;
  logic [WORD_W-1:0] byte_total;
  logic [WORD_W-1:0] expected_hashes[$];

  int unsigned err_cnt;
  int unsigned word_cnt;
  int unsigned msg_cnt;
  int unsigned empty_cnt;

  initial begin
    mismatches     = 0;
    hashes_waiting = 0;
    words_seen     = 0;
    messages_seen  = 0;
    empty_messages = 0;
    err_cnt        = 0;
    word_cnt       = 0;
    msg_cnt        = 0;
    empty_cnt      = 0;
    hash_state     = '0;
    byte_total     = '0;
  end

  function automatic logic [WORD_W-1:0] rol32(input logic [WORD_W-1:0] v,
                                              input int unsigned r);
    return (v << r) | (v >> (WORD_W - r));
  endfunction

  // Key scramble: multiply, rotate by 15, multiply.
  function automatic logic [WORD_W-1:0] scramble_key(input logic [WORD_W-1:0] k);
    logic [WORD_W-1:0] v;
    v = k * MUR_C1;
    v = rol32(v, 15);
    v = v * MUR_C2;
    return v;
  endfunction

  // Final avalanche so that every input bit reaches every output bit.
  function automatic logic [WORD_W-1:0] final_mix(input logic [WORD_W-1:0] h);
    logic [WORD_W-1:0] v;
    v = h ^ (h >> 16);
    v = v * MUR_F1;
    v = v ^ (v >> 13);
    v = v * MUR_F2;
    v = v ^ (v >> 16);
    return v;
  endfunction

  // Folds one accepted item into the prediction and queues a hash on last.
  task automatic absorb_item(input logic [WORD_W-1:0] w, input logic wv,
                             input logic lst);
    logic [WORD_W-1:0] h;
    if (wv) begin
      h          = rol32(hash_state ^ scramble_key(w), 13);
      hash_state = h * 32'd5 + MUR_ADD;
      byte_total = byte_total + BYTES_PER_WORD;
      word_cnt++;
    end
    if (lst) begin
      if (byte_total == '0) empty_cnt++;
      expected_hashes.push_back(final_mix(hash_state ^ byte_total));
      hash_state = '0;
      byte_total = '0;
      msg_cnt++;
    end
  endtask

  task automatic flag_error(input string what, input logic [WORD_W-1:0] want,
                            input logic [WORD_W-1:0] got);
    err_cnt++;
    if (err_cnt <= 10)
      $display("%0t ns: hash %s: expected %08h, got %08h", $time, what, want, got);
  endtask

  // Both channels are sampled at the rising edge, before the stimulus moves on.
  always @(posedge clk) begin
    if (rst) begin
      hash_state = '0;
      byte_total = '0;
      expected_hashes.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        absorb_item(s_axis_tdata, s_axis_tuser, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_hashes.size() == 0)
          flag_error("with nothing pending", 'x, m_axis_tdata);
        else if (m_axis_tdata !== expected_hashes[0]) begin
          flag_error("mismatch", expected_hashes[0], m_axis_tdata);
          void'(expected_hashes.pop_front());
        end else
          void'(expected_hashes.pop_front());
      end
    end
    mismatches     <= err_cnt;
    hashes_waiting <= expected_hashes.size();
    words_seen     <= word_cnt;
    messages_seen  <= msg_cnt;
    empty_messages <= empty_cnt;
  end

endmodule

@@ tb/murmur3_word_stream_hash_top_tb.sv @@
// Top of the hash block's testbench: clock, reset, word stream stimulus and the
// output stall pattern; the checker module scores the results.
// Depends on murmur3_word_stream_hash_top and murmur3_word_stream_hash_checker.
module murmur3_word_stream_hash_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WORD_TARGET = 900;
  localparam int unsigned HOLD_AT     = 200;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned CALM_FROM   = 450;
  localparam int unsigned CALM_TO     = 650;
  localparam int unsigned IDLE_PCT    = 18;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;

  int unsigned mismatches;
  int unsigned hashes_waiting;
  int unsigned words_seen;
  int unsigned messages_seen;
  int unsigned empty_messages;

  // Items accepted by the block so far; only the sender writes it.
  int unsigned items_sent = 0;
  int unsigned words_offered = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  murmur3_word_stream_hash_top DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  murmur3_word_stream_hash_checker scoreboard (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .mismatches    (mismatches),
    .hashes_waiting(hashes_waiting),
    .words_seen    (words_seen),
    .messages_seen (messages_seen),
    .empty_messages(empty_messages)
  );

  // Neither side idles while this window of items goes through.
  function automatic bit calm_phase();
    return items_sent >= CALM_FROM && items_sent < CALM_TO;
  endfunction

  // Mostly random words, with all-zero, all-one and single-bit patterns mixed in.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      2:       return 32'h1 << $urandom_range(0, 31);
      3:       return ~(32'h1 << $urandom_range(0, 31));
      default: return $urandom();
    endcase
  endfunction

  // Offers one item, idling at random first, and returns once it is accepted.
  task automatic offer_item(input logic [31:0] w, input logic wv, input logic lst);
    while (!calm_phase() && $urandom_range(0, 99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    s_axis_tuser  <= wv;
    s_axis_tlast  <= lst;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    items_sent++;
    if (wv) words_offered++;
  endtask

  // One message of n words with random filler items between them; the last
  // word either carries the last flag or is followed by a lone last item.
  task automatic offer_message(input int unsigned n_words);
    bit lone_last;
    lone_last = ($urandom_range(0, 3) == 0);
    for (int unsigned i = 0; i < n_words; i++) begin
      if ($urandom_range(0, 9) == 0) offer_item(pick_word(), 1'b0, 1'b0);
      offer_item(pick_word(), 1'b1, (i == n_words - 1) && !lone_last);
    end
    if (lone_last || n_words == 0) offer_item(pick_word(), 1'b0, 1'b1);
  endtask

  // Output side: random stalls, one long hold-off to back the block up.
  initial begin
    bit held;
    held = 1'b0;
    m_axis_tready <= 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!held && items_sent >= HOLD_AT) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      m_axis_tready <= calm_phase() ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Watchdog on the whole run.
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Stimulus and verdict.
  initial begin
    int unsigned r;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    s_axis_tlast  <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty messages, then single-word extremes with last on the word.
    offer_item(32'h0000_0000, 1'b0, 1'b1);
    offer_item(32'hffff_ffff, 1'b0, 1'b1);
    offer_item(32'h0000_0000, 1'b1, 1'b1);
    offer_item(32'hffff_ffff, 1'b1, 1'b1);
    offer_item(32'h5555_5555, 1'b1, 1'b1);
    offer_item(32'haaaa_aaaa, 1'b1, 1'b1);
    // Items with neither a word nor last leave the state alone.
    offer_item(32'ha5a5_a5a5, 1'b0, 1'b0);
    offer_item(32'h8000_0001, 1'b1, 1'b0);
    offer_item(32'hffff_ffff, 1'b0, 1'b0);
    offer_item(32'h7fff_fffe, 1'b1, 1'b0);
    offer_item(32'h0000_0000, 1'b0, 1'b1);
    // Multi-word messages ending on a valid word and on a lone last item.
    offer_item(32'h0000_0001, 1'b1, 1'b0);
    offer_item(32'h8000_0000, 1'b1, 1'b0);
    offer_item(32'hdead_beef, 1'b1, 1'b1);
    offer_item(32'h1234_5678, 1'b1, 1'b0);
    offer_item(32'h9abc_def0, 1'b1, 1'b0);
    offer_item(32'h0f0f_0f0f, 1'b0, 1'b1);
    // Two more empty messages back to back.
    offer_item(32'h0000_0000, 1'b0, 1'b1);
    offer_item(32'hffff_ffff, 1'b0, 1'b1);

    // Random messages, mostly short so that hashes come often.
    while (words_offered < WORD_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 6)       offer_message(0);
      else if (r < 80) offer_message($urandom_range(1, 6));
      else if (r < 97) offer_message($urandom_range(7, 24));
      else             offer_message($urandom_range(60, 100));
    end
    s_axis_tvalid <= 1'b0;

    // Let the scoreboard count the final item, drain, then give the pipeline
    // time to show any stray result.
    @(posedge clk);
    while (hashes_waiting != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    $display("Hashed %0d messages (%0d empty) from %0d words in %0d items,",
             messages_seen, empty_messages, words_seen, items_sent);
    $display("with random stalls on both sides and a %0d-cycle output hold-off.",
             HOLD_CYCLES);
    if (mismatches == 0 && hashes_waiting == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
